FILE: rtl/core/sps_pkg.sv
// shared constants, register index codes and the case-fold helper for the
// substring position search block; no dependencies
package sps_pkg;

   localparam int          MAX_NEEDLE_DEF = 8;
   localparam longint unsigned MAX_LEN_DEF = 64'd1048576;

   // fixed widths of the register and stream fields
   localparam int POS_W    = 21;
   localparam int NEEDLE_W = 64;
   localparam int NLEN_W   = 4;
   localparam int CSR_IX_W = 3;

   // configuration register indexes
   localparam logic [CSR_IX_W-1:0] CSR_NEEDLE_BYTES = 3'd0;
   localparam logic [CSR_IX_W-1:0] CSR_NEEDLE_LEN   = 3'd1;
   localparam logic [CSR_IX_W-1:0] CSR_SEARCH_LAST  = 3'd2;
   localparam logic [CSR_IX_W-1:0] CSR_START_POS    = 3'd3;
   localparam logic [CSR_IX_W-1:0] CSR_CASELESS     = 3'd4;

   localparam logic [7:0] ASCII_LOWER_A = 8'h61;
   localparam logic [7:0] ASCII_LOWER_Z = 8'h7a;
   localparam logic [7:0] ASCII_CASE_BIT = 8'h20;

   // ascii a-z to upper case when enabled
   function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic en);
      logic [7:0] r;
      r = b;
      if (en && b >= ASCII_LOWER_A && b <= ASCII_LOWER_Z) begin
         r = b - ASCII_CASE_BIT;
      end
      return r;
   endfunction

endpackage

FILE: rtl/core/substring_position_search.sv
// top level of the substring position search block: input word register,
// parallel window compare, match tracking and result register; uses sps_pkg
//
// The haystack enters one byte per req word and one word can be taken in every
// clock cycle; the only thing that holds req_tready low is a finished result
// that the rsp side has not yet taken while the next string end is waiting.
// A word is registered on entry, compared against the needle in the next
// cycle (all needle bytes in parallel against the newest window of bytes), and
// a word with req_tlast set puts its match position into the rsp register.
// match_pos is the 1-based start of the first match at or after start_pos
// (search_last = 0) or of the last match ending within the first start_pos
// bytes (search_last = 1), and 0 when there is none. req_tuser = 0 marks a
// word that carries no byte. Registers are written through the csr channel,
// which is always ready, and should only change between strings.
module substring_position_search #(
   parameter int              MAX_NEEDLE = sps_pkg::MAX_NEEDLE_DEF,
   parameter longint unsigned MAX_LEN    = sps_pkg::MAX_LEN_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // configuration write
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [sps_pkg::CSR_IX_W-1:0]  csr_index,
   input  logic [sps_pkg::NEEDLE_W-1:0]  csr_wdata,
   // haystack words
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,   // [7:0] data_byte
   input  logic                          req_tuser,   // [0] byte_valid
   input  logic                          req_tlast,   // last_byte
   // match results
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [23:0]                   rsp_tdata    // [20:0] match_pos, [23:21] zero
);

   localparam int CW = $clog2(MAX_LEN + 1);
   localparam int LW = $clog2(MAX_NEEDLE + 1);
   localparam int IW = (MAX_NEEDLE > 1) ? $clog2(MAX_NEEDLE) : 1;
   localparam int WD = 2 ** IW;
   localparam int EW = (CW > sps_pkg::POS_W) ? CW : sps_pkg::POS_W;
   localparam int PW = sps_pkg::POS_W;

   // configuration registers
   logic [sps_pkg::NEEDLE_W-1:0] needle_ff;
   logic [sps_pkg::NLEN_W-1:0]   nlen_ff;
   logic                         last_mode_ff;
   logic [PW-1:0]                start_ff;
   logic                         caseless_ff;

   // input word register
   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_data_ff;
   logic       s1_bvalid_ff;
   logic       s1_last_ff;

   // string state
   logic [8*MAX_NEEDLE-1:0] window_ff, window_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [PW-1:0]           found_at_ff, found_at_in;
   logic                    found_ff, found_in;

   // result register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [PW-1:0] rsp_pos_ff, rsp_pos_in;

   logic                    s1_adv;
   logic                    s1_fire;
   logic                    take_byte;
   logic [8*MAX_NEEDLE-1:0] win_new;
   logic [CW-1:0]           count_new;
   logic [LW-1:0]           n_eff;
   logic [7:0]              win_b [WD];
   logic [LW-1:0]           idx_a [MAX_NEEDLE];
   logic [MAX_NEEDLE-1:0]   byte_ok;
   logic                    hit;
   logic [EW-1:0]           begin_e;
   logic [EW-1:0]           count_e;
   logic [EW-1:0]           start_e;
   logic                    hit_ok;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         needle_ff    <= '0;
         nlen_ff      <= '0;
         last_mode_ff <= 1'b0;
         start_ff     <= PW'(1);
         caseless_ff  <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index)
            sps_pkg::CSR_NEEDLE_BYTES: needle_ff    <= csr_wdata;
            sps_pkg::CSR_NEEDLE_LEN:   nlen_ff      <= csr_wdata[sps_pkg::NLEN_W-1:0];
            sps_pkg::CSR_SEARCH_LAST:  last_mode_ff <= csr_wdata[0];
            sps_pkg::CSR_START_POS:    start_ff     <= csr_wdata[PW-1:0];
            sps_pkg::CSR_CASELESS:     caseless_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // pipeline handshake
   assign s1_adv     = s1_valid_ff && (!s1_last_ff || !rsp_valid_ff || rsp_tready);
   assign s1_fire    = s1_adv;
   assign req_tready = !s1_valid_ff || s1_adv;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_tvalid && req_tready) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_data_ff   <= req_tdata;
         s1_bvalid_ff <= req_tuser;
         s1_last_ff   <= req_tlast;
      end
   end

   // window compare
   assign take_byte = s1_bvalid_ff && (count_ff < CW'(MAX_LEN));
   assign count_new = count_ff + CW'(1);
   assign n_eff     = (nlen_ff > sps_pkg::NLEN_W'(MAX_NEEDLE)) ? LW'(MAX_NEEDLE)
                                                                : LW'(nlen_ff);
   if (MAX_NEEDLE > 1) begin : g_shift
      assign win_new = {window_ff[8*(MAX_NEEDLE-1)-1:0], s1_data_ff};
   end else begin : g_single
      assign win_new = s1_data_ff;
   end

   always_comb begin
      for (int j = 0; j < WD; j++) begin
         win_b[j] = (j < MAX_NEEDLE) ? win_new[8*j +: 8] : 8'h00;
      end
   end

   // needle byte i lines up with window byte n-1-i (byte 0 is the newest)
   always_comb begin
      for (int i = 0; i < MAX_NEEDLE; i++) begin
         idx_a[i]   = n_eff - LW'(i) - LW'(1);
         byte_ok[i] = (LW'(i) >= n_eff) ||
                      (sps_pkg::fold_byte(needle_ff[8*i +: 8], caseless_ff) ==
                       sps_pkg::fold_byte(win_b[idx_a[i][IW-1:0]], caseless_ff));
      end
   end

   assign hit     = (n_eff != '0) && (count_new >= CW'(n_eff)) && (&byte_ok);
   assign count_e = EW'(count_new);
   assign begin_e = count_e - EW'(n_eff) + EW'(1);
   assign start_e = EW'(start_ff);
   assign hit_ok  = last_mode_ff ? (count_e <= start_e)
                                 : (!found_ff && begin_e >= start_e);

   always_comb begin
      window_in    = window_ff;
      count_in     = count_ff;
      found_at_in  = found_at_ff;
      found_in     = found_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_pos_in   = rsp_pos_ff;
      if (s1_fire) begin
         if (take_byte) begin
            window_in = win_new;
            count_in  = count_new;
            if (hit && hit_ok) begin
               found_at_in = begin_e[PW-1:0];
               found_in    = 1'b1;
            end
         end
         if (s1_last_ff) begin
            rsp_valid_in = 1'b1;
            rsp_pos_in   = found_in ? found_at_in : '0;
            window_in    = '0;
            count_in     = '0;
            found_at_in  = '0;
            found_in     = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         window_ff    <= '0;
         count_ff     <= '0;
         found_at_ff  <= '0;
         found_ff     <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         window_ff    <= window_in;
         count_ff     <= count_in;
         found_at_ff  <= found_at_in;
         found_ff     <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_pos_ff <= rsp_pos_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_pos_ff};

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_LEN))
      else $error("byte count past maximum string length");

   a_clear_after_end: assert property (@(posedge clock) disable iff (reset)
      s1_fire && s1_last_ff |=> count_ff == '0 && !found_ff)
      else $error("string state not cleared after end word");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(s1_fire && s1_last_ff))
      else $error("result raised without an end word");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> s1_valid_ff && s1_last_ff && rsp_valid_ff && !rsp_tready)
      else $error("input stalled without a blocked result");

endmodule
